// ----- sv/tts_pkg.sv -----
// Package for the tick task scheduler: types, codes and sizes.
package tts_pkg;

   localparam int NUM_TASKS = 8;
   localparam int IDX_W = 3;
   localparam int CNT_W = 4;
   localparam int TIME_W = 32;

   typedef enum logic [2:0] {
      ACT_REGISTER = 3'd0,
      ACT_DISPATCH = 3'd1,
      ACT_FINISH   = 3'd2,
      ACT_RECOVER  = 3'd3,
      ACT_SUSPEND  = 3'd4,
      ACT_STANDBY  = 3'd5
   } action_type;

   localparam logic [1:0] ST_READY = 2'd0;
   localparam logic [1:0] ST_TIMER = 2'd1;
   localparam logic [1:0] ST_SUSP  = 2'd2;
   localparam logic [1:0] ST_STBY  = 2'd3;

   typedef struct packed {
      logic [2:0]        action;
      logic [IDX_W-1:0]  task_req;
      logic [TIME_W-1:0] now;
      logic [TIME_W-1:0] ticks;
      logic              mode;
      logic [1:0]        status;
   } req_type;

   typedef struct packed {
      logic             run_valid;
      logic [IDX_W-1:0] run_task;
      logic [1:0]       task_status;
      logic             ignored;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RD_TASK,
      S_DECIDE,
      S_REL_RD,
      S_REL_CHK,
      S_DROP_R,
      S_DROP_W,
      S_INS_RD,
      S_INS_CHK,
      S_INS_SHIFT,
      S_PUSH,
      S_RESP,
      S_OUT
   } state_type;

endpackage

// ----- sv/tick_task_scheduler.sv -----
// Tick task scheduler top level: request sequencer over a task-record memory.
//
// Channel  Direction  Handshake           Payload
// req      in         req_valid/ready     tts_pkg::req_type
// rsp      out        rsp_valid/ready     tts_pkg::rsp_type
//
// One transaction is handled at a time; its length is set by the walks over
// the queue arrays (release, removal and sorted insertion); release and sorted
// insertion read each entry's deadline from the record memory.
// Reset clears sequencer state, queue counts and running task; tasks go to standby.
// A result waits in the output register; the next request is taken then too,
// and its result holds in the response step until the register is free.
module tick_task_scheduler (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tts_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tts_pkg::rsp_type rsp_data
);

   localparam int IW = tts_pkg::IDX_W;
   localparam int CW = tts_pkg::CNT_W;
   localparam int TW = tts_pkg::TIME_W;
   localparam int N  = tts_pkg::NUM_TASKS;

   // Per-task records live in one synchronous memory: kind, period, deadline.
   logic [2*TW:0] rec_mem [N];
   logic [TW-1:0] dl_rd_ff;
   logic [TW-1:0] per_rd_ff;
   logic          kind_rd_ff;
   logic [IW-1:0] rd_addr;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [TW-1:0] wr_dl;
   logic          wr_rec;

   // Queue arrays, registers read at indexed position with shifts.
   logic [IW-1:0] rq_ff [N];
   logic [IW-1:0] rq_in [N];
   logic [IW-1:0] wq_ff [N];
   logic [IW-1:0] wq_in [N];
   logic [1:0]    st_ff [N];
   logic [1:0]    st_in [N];
   logic [CW-1:0] rc_ff, rc_in, wc_ff, wc_in;
   logic [TW-1:0] last_ff, last_in;
   logic [IW-1:0] run_ff, run_in;
   logic          runv_ff, runv_in;

   tts_pkg::state_type state_ff, state_in;
   tts_pkg::req_type   req_ff, req_in;
   tts_pkg::rsp_type   out_ff, out_in;
   logic               outv_ff, outv_in;
   logic [IW-1:0]      tk_ff, tk_in;       // task being worked on
   logic               ign_ff, ign_in;
   logic               named_ff, named_in;
   logic [TW-1:0]      dl_ff, dl_in;       // new deadline of tk
   logic [CW-1:0]      pos_ff, pos_in;
   logic [1:0]         after_ff, after_in; // 0 none,1 push,2 insert
   logic               reldone_ff, reldone_in;
   logic [CW-1:0]      qsel_ff, qsel_in;   // 2 skips the drop pass

   localparam logic [1:0] AF_NONE = 2'd0;
   localparam logic [1:0] AF_PUSH = 2'd1;
   localparam logic [1:0] AF_INS  = 2'd2;

   // Writes keep the kind and period read for the same task unless registering.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         rec_mem[wr_addr] <= {(wr_rec ? req_ff.mode : kind_rd_ff),
                              (wr_rec ? req_ff.ticks : per_rd_ff), wr_dl};
      end
      {kind_rd_ff, per_rd_ff, dl_rd_ff} <= rec_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tts_pkg::S_IDLE;
         outv_ff  <= 1'b0;
         rc_ff    <= '0;
         wc_ff    <= '0;
         last_ff  <= '0;
         run_ff   <= '0;
         runv_ff  <= 1'b0;
         for (int i = 0; i < N; i++) st_ff[i] <= tts_pkg::ST_STBY;
      end else begin
         state_ff <= state_in;
         outv_ff  <= outv_in;
         rc_ff    <= rc_in;
         wc_ff    <= wc_in;
         last_ff  <= last_in;
         run_ff   <= run_in;
         runv_ff  <= runv_in;
         st_ff    <= st_in;
      end
      rq_ff      <= rq_in;
      wq_ff      <= wq_in;
      req_ff     <= req_in;
      out_ff     <= out_in;
      tk_ff      <= tk_in;
      ign_ff     <= ign_in;
      named_ff   <= named_in;
      dl_ff      <= dl_in;
      pos_ff     <= pos_in;
      after_ff   <= after_in;
      reldone_ff <= reldone_in;
      qsel_ff    <= qsel_in;
   end

   logic [IW-1:0] pos_idx;
   logic [IW-1:0] wq_head;
   logic [1:0]    tk_st;
   logic          is_expired;
   logic          pos_last;
   logic          found;

   assign pos_idx = pos_ff[IW-1:0];
   assign wq_head = wq_ff[0];
   assign tk_st   = st_ff[tk_ff];

   always_comb begin
      logic [TW-1:0] diff;
      diff = req_ff.now - dl_rd_ff;
      is_expired = ~diff[TW-1];
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tts_pkg::S_IDLE: if (req_valid) state_in = tts_pkg::S_RD_TASK;
         tts_pkg::S_RD_TASK: begin
            if (req_ff.action == tts_pkg::ACT_DISPATCH) begin
               if (req_ff.now != last_ff && wc_ff != '0) state_in = tts_pkg::S_REL_CHK;
               else state_in = tts_pkg::S_RESP;
            end else begin
               state_in = tts_pkg::S_DECIDE;
            end
         end
         tts_pkg::S_DECIDE: state_in = tts_pkg::S_DROP_R;
         tts_pkg::S_REL_RD: state_in = tts_pkg::S_REL_CHK;
         tts_pkg::S_REL_CHK: begin
            if (is_expired && !reldone_ff) state_in = tts_pkg::S_REL_RD;
            else state_in = tts_pkg::S_RESP;
            if (is_expired && !reldone_ff && wc_ff == CW'(1)) state_in = tts_pkg::S_RESP;
         end
         tts_pkg::S_DROP_R: if (pos_last) state_in = tts_pkg::S_DROP_W;
         tts_pkg::S_DROP_W: begin
            if (after_ff == AF_INS && wc_ff != CW'(N) && wc_ff != '0)
               state_in = tts_pkg::S_INS_RD;
            else state_in = tts_pkg::S_PUSH;
         end
         tts_pkg::S_INS_RD: state_in = tts_pkg::S_INS_CHK;
         tts_pkg::S_INS_CHK: begin
            if (dl_ff < dl_rd_ff) state_in = tts_pkg::S_INS_SHIFT;
            else if (pos_ff + CW'(1) == wc_ff) state_in = tts_pkg::S_INS_SHIFT;
            else state_in = tts_pkg::S_INS_RD;
         end
         tts_pkg::S_INS_SHIFT: state_in = tts_pkg::S_RESP;
         tts_pkg::S_PUSH: state_in = tts_pkg::S_RESP;
         tts_pkg::S_RESP: if (!outv_ff || rsp_ready) state_in = tts_pkg::S_OUT;
         tts_pkg::S_OUT: if (!outv_ff || rsp_ready) state_in = tts_pkg::S_IDLE;
         default: state_in = tts_pkg::S_IDLE;
      endcase
   end

   assign pos_last = (pos_ff == CW'(N - 1));

   // Datapath and outputs.
   always_comb begin
      logic [IW-1:0] t;
      logic          bad;
      logic [TW-1:0] sum;
      req_in = req_ff; out_in = out_ff; outv_in = outv_ff;
      tk_in = tk_ff; ign_in = ign_ff;
      named_in = named_ff; dl_in = dl_ff; pos_in = pos_ff; after_in = after_ff;
      reldone_in = reldone_ff; qsel_in = qsel_ff;
      rq_in = rq_ff; wq_in = wq_ff; st_in = st_ff;
      rc_in = rc_ff; wc_in = wc_ff; last_in = last_ff;
      run_in = run_ff; runv_in = runv_ff;
      rd_addr = tk_ff; wr_en = 1'b0; wr_addr = tk_ff; wr_dl = dl_ff; wr_rec = 1'b0;
      req_ready = 1'b0;
      found = 1'b0;
      t = req_ff.task_req;
      bad = 1'b0;
      sum = '0;
      if (outv_ff && rsp_ready) outv_in = 1'b0;
      unique case (state_ff)
         tts_pkg::S_IDLE: begin
            req_ready = 1'b1;
            req_in = req_data;
            if (req_valid) begin
               tk_in = (req_data.action == tts_pkg::ACT_FINISH) ? run_ff
                                                                 : req_data.task_req;
               ign_in = 1'b0;
               named_in = 1'b1;
               reldone_in = 1'b0;
               after_in = AF_NONE;
               pos_in = '0;
               qsel_in = '0;
            end
            rd_addr = (req_data.action == tts_pkg::ACT_FINISH) ? run_ff
                                                                : req_data.task_req;
         end
         tts_pkg::S_RD_TASK: begin
            // Dispatch reads the waiting head; other requests keep the task record.
            rd_addr = (req_ff.action == tts_pkg::ACT_DISPATCH) ? wq_head : tk_ff;
            if (req_ff.action == tts_pkg::ACT_DISPATCH && req_ff.now != last_ff
                && wc_ff != '0) begin
               tk_in = wq_head;
            end
         end
         tts_pkg::S_REL_RD: rd_addr = wq_head;
         tts_pkg::S_REL_CHK: begin
            rd_addr = wq_ff[1];
            if (is_expired && !reldone_ff) begin
               for (int i = 0; i < N - 1; i++) wq_in[i] = wq_ff[i + 1];
               wc_in = wc_ff - CW'(1);
               if (rc_ff != CW'(N)) begin
                  rq_in[rc_ff[IW-1:0]] = wq_head;
                  rc_in = rc_ff + CW'(1);
               end
               st_in[wq_head] = tts_pkg::ST_READY;
               tk_in = wq_ff[1];
               if (wc_ff == CW'(1)) reldone_in = 1'b1;
            end else begin
               reldone_in = 1'b1;
            end
         end
         tts_pkg::S_DECIDE: begin
            // Record read is valid; decide the action.
            bad = 1'b0;
            if (req_ff.action == tts_pkg::ACT_FINISH) begin
               if (!runv_ff) begin
                  // With no running task the result reports the requested task.
                  ign_in = 1'b1; tk_in = req_ff.task_req; bad = 1'b1;
               end else begin
                  runv_in = 1'b0;
                  if (tk_st == tts_pkg::ST_STBY) begin
                     ign_in = 1'b1; bad = 1'b1;
                  end else if (kind_rd_ff) begin
                     if (tk_st == tts_pkg::ST_TIMER && is_expired) begin
                        st_in[tk_ff] = tts_pkg::ST_STBY;
                        after_in = AF_NONE;
                     end else after_in = AF_PUSH;
                  end else if (tk_st == tts_pkg::ST_SUSP) begin
                     ign_in = 1'b1; bad = 1'b1;
                  end else begin
                     sum = per_rd_ff + req_ff.now;
                     st_in[tk_ff] = tts_pkg::ST_SUSP;
                     dl_in = sum; wr_en = 1'b1; wr_dl = sum;
                     after_in = AF_INS;
                  end
               end
            end else if (req_ff.action > tts_pkg::ACT_STANDBY || 32'(req_ff.task_req) >= N)
            begin
               ign_in = 1'b1; bad = 1'b1;
               named_in = (32'(req_ff.task_req) < N);
            end else begin
               unique case (req_ff.action)
                  tts_pkg::ACT_REGISTER: begin
                     sum = req_ff.ticks + req_ff.now;
                     st_in[t] = req_ff.status;
                     dl_in = sum; wr_en = 1'b1; wr_dl = sum; wr_rec = 1'b1;
                     after_in = (req_ff.status == tts_pkg::ST_STBY) ? AF_NONE : AF_PUSH;
                  end
                  tts_pkg::ACT_RECOVER: begin
                     if (tk_st == tts_pkg::ST_READY || tk_st == tts_pkg::ST_TIMER) begin
                        ign_in = 1'b1; bad = 1'b1;
                     end else begin
                        sum = per_rd_ff + req_ff.now;
                        st_in[t] = req_ff.status;
                        dl_in = sum; wr_en = 1'b1; wr_dl = sum;
                        if (req_ff.status == tts_pkg::ST_SUSP) after_in = AF_INS;
                        else if (req_ff.status == tts_pkg::ST_STBY) after_in = AF_NONE;
                        else after_in = AF_PUSH;
                     end
                  end
                  tts_pkg::ACT_SUSPEND: begin
                     if (kind_rd_ff || tk_st == tts_pkg::ST_SUSP) begin
                        ign_in = 1'b1; bad = 1'b1;
                     end else begin
                        sum = req_ff.ticks + req_ff.now;
                        st_in[t] = tts_pkg::ST_SUSP;
                        dl_in = sum; wr_en = 1'b1; wr_dl = sum;
                        after_in = AF_INS;
                     end
                  end
                  default: begin
                     if (tk_st == tts_pkg::ST_STBY) begin
                        ign_in = 1'b1; bad = 1'b1;
                     end else begin
                        st_in[t] = tts_pkg::ST_STBY;
                        after_in = AF_NONE;
                     end
                  end
               endcase
            end
            // Ignored requests skip the queue work by walking nothing.
            qsel_in = bad ? CW'(2) : '0;
            pos_in = '0;
         end
         tts_pkg::S_DROP_R: begin
            // Drop tk from both queues: one slot per cycle unless one is found.
            if (qsel_ff != CW'(2)) begin
               if (pos_ff < rc_ff && rq_ff[pos_idx] == tk_ff) begin
                  for (int i = 0; i < N - 1; i++)
                     if (CW'(i) >= pos_ff) rq_in[i] = rq_ff[i + 1];
                  rc_in = rc_ff - CW'(1);
                  found = 1'b1;
               end
               if (pos_ff < wc_ff && wq_ff[pos_idx] == tk_ff) begin
                  for (int i = 0; i < N - 1; i++)
                     if (CW'(i) >= pos_ff) wq_in[i] = wq_ff[i + 1];
                  wc_in = wc_ff - CW'(1);
                  found = 1'b1;
               end
               // After a removal the same slot holds a new entry: stay.
               if (!found) pos_in = pos_ff + CW'(1);
               if (found) pos_in = pos_ff;
            end else begin
               pos_in = CW'(N - 1);
            end
            if (pos_last) pos_in = '0;
         end
         tts_pkg::S_DROP_W: begin
            if (qsel_ff == CW'(2)) after_in = AF_NONE;
            pos_in = '0;
            rd_addr = wq_ff[0];
         end
         tts_pkg::S_INS_RD: rd_addr = wq_ff[pos_idx];
         tts_pkg::S_INS_CHK: begin
            if (dl_ff < dl_rd_ff) pos_in = pos_ff;
            else pos_in = pos_ff + CW'(1);
            rd_addr = wq_ff[IW'(pos_ff + CW'(1))];
         end
         tts_pkg::S_INS_SHIFT: begin
            for (int i = 1; i < N; i++)
               if (CW'(i) > pos_ff) wq_in[i] = wq_ff[i - 1];
            wq_in[pos_idx] = tk_ff;
            wc_in = wc_ff + CW'(1);
         end
         tts_pkg::S_PUSH: begin
            if (after_ff == AF_PUSH && rc_ff != CW'(N)) begin
               rq_in[rc_ff[IW-1:0]] = tk_ff;
               rc_in = rc_ff + CW'(1);
            end
            // Insert into an empty waiting list.
            if (after_ff == AF_INS && wc_ff == '0) begin
               wq_in[0] = tk_ff;
               wc_in = CW'(1);
            end
         end
         tts_pkg::S_RESP: begin
            // The output register is loaded only when empty or its result is taken.
            if (!outv_ff || rsp_ready) begin
               if (req_ff.action == tts_pkg::ACT_DISPATCH) begin
                  last_in = req_ff.now;
                  if (rc_ff != '0) begin
                     run_in = rq_ff[0]; runv_in = 1'b1;
                     out_in.run_valid = 1'b1;
                     out_in.run_task = rq_ff[0];
                     out_in.task_status = st_ff[rq_ff[0]];
                  end else begin
                     runv_in = 1'b0;
                     out_in.run_valid = 1'b0;
                     out_in.run_task = '0;
                     out_in.task_status = (32'(req_ff.task_req) < N)
                                          ? st_ff[req_ff.task_req] : 2'd0;
                  end
                  out_in.ignored = 1'b0;
               end else begin
                  out_in.run_valid = 1'b0;
                  out_in.run_task = '0;
                  out_in.task_status = named_ff ? st_ff[tk_ff] : 2'd0;
                  out_in.ignored = ign_ff;
               end
            end
         end
         tts_pkg::S_OUT: begin
            if (!outv_ff || rsp_ready) outv_in = 1'b1;
         end
         default: ;
      endcase
   end

   assign rsp_valid = outv_ff;
   assign rsp_data  = out_ff;

endmodule

// ----- sim/tick_task_scheduler_test.sv -----
// Self-checking testbench for the tick task scheduler with a built-in predictor.
`timescale 1ns / 100ps

module tick_task_scheduler_test;

   localparam int NT = tts_pkg::NUM_TASKS;
   localparam int TW = tts_pkg::TIME_W;
   localparam int IW = tts_pkg::IDX_W;
   localparam logic [2:0] ACT_UNDEF6 = 3'd6;
   localparam logic [2:0] ACT_UNDEF7 = 3'd7;
   localparam int RANDOM_ITEMS = 1280;

   typedef struct {
      tts_pkg::req_type item;
      bit               drain_first;
   } pending_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   tts_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   tts_pkg::rsp_type rsp_data;

   tick_task_scheduler uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Predictor state.
   logic          kind_q [NT];
   logic [1:0]    state_q [NT];
   logic [TW-1:0] period_q [NT];
   logic [TW-1:0] deadline_q [NT];
   int            ready_fifo [$];
   int            wait_list [$];
   logic [TW-1:0] last_tick;
   int            cur_task;
   bit            cur_valid;

   pending_type      pending [$];
   tts_pkg::rsp_type expected_rsp [$];
   int               errors = 0;
   int               accepted_reqs = 0;
   bit               stimulus_done = 0;
   bit               req_fired = 0;

   function automatic bit has_expired(logic [TW-1:0] t_now, logic [TW-1:0] dl);
      logic [TW-1:0] diff;
      diff = t_now - dl;
      return diff < 32'h8000_0000;
   endfunction

   function automatic void unlink(int t);
      foreach (ready_fifo[i]) if (ready_fifo[i] == t) begin
         ready_fifo.delete(i);
         break;
      end
      foreach (wait_list[i]) if (wait_list[i] == t) begin
         wait_list.delete(i);
         break;
      end
   endfunction

   function automatic void insert_by_deadline(int t);
      int pos;
      pos = 0;
      while (pos < wait_list.size() && !(deadline_q[t] < deadline_q[wait_list[pos]]))
         pos++;
      wait_list.insert(pos, t);
   endfunction

   function automatic void place(int t);
      unlink(t);
      if (state_q[t] == tts_pkg::ST_READY || state_q[t] == tts_pkg::ST_TIMER)
         ready_fifo.push_back(t);
      else if (state_q[t] == tts_pkg::ST_SUSP) insert_by_deadline(t);
   endfunction

   function automatic bit try_suspend(int t, logic [TW-1:0] delay, logic [TW-1:0] t_now);
      if (kind_q[t] || state_q[t] == tts_pkg::ST_SUSP) return 0;
      state_q[t] = tts_pkg::ST_SUSP;
      deadline_q[t] = delay + t_now;
      place(t);
      return 1;
   endfunction

   function automatic tts_pkg::rsp_type schedule_step(tts_pkg::req_type r);
      tts_pkg::rsp_type o;
      int               t, named;
      o = '0;
      t = r.task_req;
      named = t;
      if (r.action == tts_pkg::ACT_DISPATCH) begin
         if (r.now != last_tick) begin
            while (wait_list.size() > 0 && has_expired(r.now, deadline_q[wait_list[0]])) begin
               ready_fifo.push_back(wait_list[0]);
               state_q[wait_list[0]] = tts_pkg::ST_READY;
               void'(wait_list.pop_front());
            end
            last_tick = r.now;
         end
         if (ready_fifo.size() > 0) begin
            cur_task = ready_fifo[0];
            cur_valid = 1;
            o.run_valid = 1'b1;
            o.run_task = IW'(cur_task);
            named = cur_task;
         end else begin
            cur_valid = 0;
         end
      end else if (r.action == tts_pkg::ACT_FINISH) begin
         if (!cur_valid) begin
            o.ignored = 1'b1;
         end else begin
            named = cur_task;
            cur_valid = 0;
            if (state_q[named] == tts_pkg::ST_STBY) begin
               o.ignored = 1'b1;
            end else if (kind_q[named]) begin
               unlink(named);
               if (state_q[named] == tts_pkg::ST_TIMER
                   && has_expired(r.now, deadline_q[named]))
                  state_q[named] = tts_pkg::ST_STBY;
               else
                  ready_fifo.push_back(named);
            end else if (!try_suspend(named, period_q[named], r.now)) begin
               o.ignored = 1'b1;
            end
         end
      end else if (r.action > tts_pkg::ACT_STANDBY) begin
         o.ignored = 1'b1;
      end else if (r.action == tts_pkg::ACT_REGISTER) begin
         kind_q[t] = r.mode;
         state_q[t] = r.status;
         period_q[t] = r.ticks;
         deadline_q[t] = r.ticks + r.now;
         unlink(t);
         if (r.status != tts_pkg::ST_STBY) ready_fifo.push_back(t);
      end else if (r.action == tts_pkg::ACT_RECOVER) begin
         if (state_q[t] == tts_pkg::ST_READY || state_q[t] == tts_pkg::ST_TIMER) begin
            o.ignored = 1'b1;
         end else begin
            state_q[t] = r.status;
            deadline_q[t] = period_q[t] + r.now;
            place(t);
         end
      end else if (r.action == tts_pkg::ACT_SUSPEND) begin
         if (!try_suspend(t, r.ticks, r.now)) o.ignored = 1'b1;
      end else begin
         if (state_q[t] == tts_pkg::ST_STBY) begin
            o.ignored = 1'b1;
         end else begin
            state_q[t] = tts_pkg::ST_STBY;
            unlink(t);
         end
      end
      o.task_status = state_q[named];
      return o;
   endfunction

   // Stimulus generation state: recover and suspend only name registered tasks.
   bit            registered [NT];
   logic [TW-1:0] gen_tick = '0;

   function automatic logic [TW-1:0] pick_ticks();
      int sel;
      sel = $urandom_range(0, 19);
      if (sel == 0) return '0;
      if (sel == 1) return '1;
      if (sel < 4) return $urandom;
      return $urandom_range(0, 10);
   endfunction

   task automatic add_item(logic [2:0] act, int t, logic [TW-1:0] tks,
                           logic md, logic [1:0] st, bit drain);
      pending_type p;
      p.item.action = act;
      p.item.task_req = IW'(t);
      p.item.now = gen_tick;
      p.item.ticks = tks;
      p.item.mode = md;
      p.item.status = st;
      p.drain_first = drain;
      if (act == tts_pkg::ACT_REGISTER) registered[t] = 1;
      pending.push_back(p);
   endtask

   task automatic add_random_item(bit drain);
      int         sel, t;
      logic [2:0] act;
      sel = $urandom_range(0, 99);
      if ($urandom_range(0, 49) == 0) gen_tick = $urandom;
      else gen_tick += $urandom_range(0, 3);
      t = $urandom_range(0, NT - 1);
      if (sel < 12) act = tts_pkg::ACT_REGISTER;
      else if (sel < 45) act = tts_pkg::ACT_DISPATCH;
      else if (sel < 75) act = tts_pkg::ACT_FINISH;
      else if (sel < 84) act = tts_pkg::ACT_RECOVER;
      else if (sel < 93) act = tts_pkg::ACT_SUSPEND;
      else if (sel < 98) act = tts_pkg::ACT_STANDBY;
      else act = (sel == 98) ? ACT_UNDEF6 : ACT_UNDEF7;
      if ((act == tts_pkg::ACT_RECOVER || act == tts_pkg::ACT_SUSPEND) && !registered[t])
         act = tts_pkg::ACT_REGISTER;
      add_item(act, t, pick_ticks(), 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
               drain);
   endtask

   initial begin
      for (int i = 0; i < NT; i++) begin
         state_q[i] = tts_pkg::ST_STBY;
         kind_q[i] = 1'b0;
         period_q[i] = '0;
         deadline_q[i] = '0;
         registered[i] = 0;
      end
      last_tick = '0;
      cur_task = 0;
      cur_valid = 0;

      // Directed part: empty dispatch, every action, extreme fields and the wrap.
      add_item(tts_pkg::ACT_DISPATCH, 0, '0, 1'b0, tts_pkg::ST_READY, 0);
      add_item(tts_pkg::ACT_FINISH, 0, '0, 1'b0, tts_pkg::ST_READY, 0);
      add_item(tts_pkg::ACT_STANDBY, 7, '0, 1'b0, tts_pkg::ST_READY, 0);
      add_item(tts_pkg::ACT_REGISTER, 0, 32'd5, 1'b0, tts_pkg::ST_READY, 0);
      add_item(tts_pkg::ACT_REGISTER, 1, '1, 1'b1, tts_pkg::ST_TIMER, 0);
      add_item(tts_pkg::ACT_REGISTER, 2, '0, 1'b0, tts_pkg::ST_SUSP, 0);
      add_item(tts_pkg::ACT_REGISTER, 3, 32'd2, 1'b1, tts_pkg::ST_STBY, 0);
      add_item(tts_pkg::ACT_REGISTER, 7, 32'd1, 1'b1, tts_pkg::ST_READY, 0);
      gen_tick = 32'hFFFF_FFFE;
      add_item(tts_pkg::ACT_DISPATCH, 5, '0, 1'b1, tts_pkg::ST_STBY, 0);
      add_item(tts_pkg::ACT_FINISH, 0, '0, 1'b0, tts_pkg::ST_READY, 0);
      add_item(tts_pkg::ACT_DISPATCH, 0, '0, 1'b0, tts_pkg::ST_READY, 0);
      add_item(tts_pkg::ACT_FINISH, 0, '0, 1'b0, tts_pkg::ST_READY, 0);
      add_item(tts_pkg::ACT_SUSPEND, 1, 32'd3, 1'b0, tts_pkg::ST_READY, 0);
      add_item(tts_pkg::ACT_SUSPEND, 2, 32'd3, 1'b0, tts_pkg::ST_READY, 0);
      add_item(tts_pkg::ACT_SUSPEND, 0, 32'd7, 1'b0, tts_pkg::ST_READY, 0);
      add_item(tts_pkg::ACT_RECOVER, 7, '0, 1'b0, tts_pkg::ST_SUSP, 0);
      add_item(tts_pkg::ACT_RECOVER, 3, '0, 1'b0, tts_pkg::ST_SUSP, 0);
      add_item(ACT_UNDEF6, 4, '1, 1'b1, tts_pkg::ST_STBY, 0);
      add_item(ACT_UNDEF7, 6, '1, 1'b1, tts_pkg::ST_STBY, 0);
      gen_tick = 32'd9;
      add_item(tts_pkg::ACT_DISPATCH, 0, '0, 1'b0, tts_pkg::ST_READY, 0);
      add_item(tts_pkg::ACT_FINISH, 0, '0, 1'b0, tts_pkg::ST_READY, 0);
      add_item(tts_pkg::ACT_STANDBY, 1, '0, 1'b0, tts_pkg::ST_READY, 0);
      add_item(tts_pkg::ACT_STANDBY, 1, '0, 1'b0, tts_pkg::ST_READY, 0);
      add_item(tts_pkg::ACT_RECOVER, 1, '0, 1'b0, tts_pkg::ST_STBY, 0);
      for (int n = 0; n < RANDOM_ITEMS; n++) add_random_item(n == 300 || n == 900);
   end

   // Driver: presents pending transactions at the falling edge.
   int send_gap = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (req_fired) begin
            req_fired = 0;
            req_valid <= 1'b0;
            if ($urandom_range(0, 9) < 7) send_gap = $urandom_range(0, 2);
            else if ($urandom_range(0, 9) == 0) send_gap = $urandom_range(20, 60);
            else send_gap = 0;
         end
         if (!req_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending.size() > 0) begin
               if (!pending[0].drain_first || expected_rsp.size() == 0) begin
                  req_data <= pending[0].item;
                  req_valid <= 1'b1;
                  void'(pending.pop_front());
               end
            end else begin
               stimulus_done = 1;
            end
         end
      end
   end

   // Receiver: random back-pressure plus one long hold-off.
   int  hold_cycles = 0;
   bit  long_hold_done = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (!long_hold_done && accepted_reqs >= 500) begin
            long_hold_done = 1;
            hold_cycles = 400;
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ready <= 1'b0;
         end else if ($urandom_range(0, 9) < 6) begin
            rsp_ready <= 1'b1;
         end else if ($urandom_range(0, 19) == 0) begin
            hold_cycles = $urandom_range(15, 50);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'($urandom_range(0, 1));
         end
      end
   end

   // Monitor: predicts on accepted requests and checks accepted results.
   always @(posedge clock) begin
      tts_pkg::rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_rsp.push_back(schedule_step(req_data));
            accepted_reqs++;
            req_fired = 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, actual %p", $realtime, rsp_data);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.run_valid !== want.run_valid ||
                   rsp_data.run_task !== want.run_task ||
                   rsp_data.task_status !== want.task_status ||
                   rsp_data.ignored !== want.ignored) begin
                  errors++;
                  $display("%0t: result mismatch, expected %p, actual %p",
                           $realtime, want, rsp_data);
               end
            end
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      wait (stimulus_done);
      wait (expected_rsp.size() == 0);
      repeat (60) @(posedge clock);
      if (errors == 0 && expected_rsp.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("FAIL");
      $finish;
   end

endmodule
